### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Types and constants shared by the bounded LIFO stack.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_REPLACE = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Memory access issued in the cycle of a command transfer
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

  // Command waiting on the memory read before its result is formed
  typedef struct packed {
    logic             busy;
    logic             rd;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } pend_t;

endpackage

### hw/rtl/bls_ram.sv
// ----------------------------------------------------------------------------
// bls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/bls_ctrl.sv
// ----------------------------------------------------------------------------
// bls_ctrl
// Command decode, fill count and memory access for the LIFO stack.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [1:0]                 command,
  input  logic signed [31:0]         value,
  input  logic                       take,
  output bls_pkg::mem_req_t          mem_req,
  output bls_pkg::pend_t             pend,
  output logic [bls_pkg::CNT_W-1:0]  fill
);
  import bls_pkg::*;

  logic             xfer;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] top;
  status_t          st;
  logic             do_wr;
  logic             do_rd;
  logic [PTR_W-1:0] addr;

  // Accept when the pending slot is free or drains this cycle
  assign cmd_stall = rst | (pend.busy & ~take);
  assign xfer      = cmd_valid & ~cmd_stall;
  assign top       = PTR_W'(count - CNT_W'(1));
  assign fill      = count;

  // Decode the command against the current fill count
  always_comb begin
    st         = ST_OK;
    count_next = count;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    addr       = top;
    if (cmd_e_t'(command) == CMD_PUSH) begin
      if (count == CNT_W'(DEPTH)) begin
        st = ST_OVERFLOW;
      end else begin
        do_wr      = 1'b1;
        addr       = PTR_W'(count);
        count_next = count + CNT_W'(1);
      end
    end else if (count == '0) begin
      st = ST_UNDERFLOW;
    end else begin
      case (cmd_e_t'(command))
        CMD_POP: begin
          do_rd      = 1'b1;
          count_next = count - CNT_W'(1);
        end
        CMD_PEEK: begin
          do_rd = 1'b1;
        end
        default: begin
          do_wr = 1'b1;
        end
      endcase
    end
  end

  // Memory access only on a transfer
  always_comb begin
    mem_req.wr_en   = xfer & do_wr;
    mem_req.rd_en   = xfer & do_rd;
    mem_req.addr    = addr;
    mem_req.wr_data = value;
  end

  // Fill count and pending command
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend.busy <= 1'b0;
    end else if (xfer) begin
      count     <= count_next;
      pend.busy <= 1'b1;
    end else if (take) begin
      pend.busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      pend.rd        <= do_rd;
      pend.status    <= st;
      pend.occupancy <= OCC_W'(count_next);
    end
  end

endmodule

### hw/rtl/bls_out.sv
// ----------------------------------------------------------------------------
// bls_out
// Result register: joins read data with the pending command's status.
// ----------------------------------------------------------------------------
module bls_out (
  input  logic                        clk,
  input  logic                        rst,
  input  bls_pkg::pend_t              pend,
  input  logic [bls_pkg::WORD_W-1:0]  rd_data,
  output logic                        take,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic signed [31:0]          data,
  output logic [1:0]                  status,
  output logic [4:0]                  occupancy
);
  import bls_pkg::*;

  // Load when a result is pending and the register is free or draining
  assign take = pend.busy & (~rsp_valid | ~rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (~rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data      <= pend.rd ? signed'(rd_data) : '0;
      status    <= pend.status;
      occupancy <= pend.occupancy;
    end
  end

endmodule

### hw/rtl/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack of signed 32-bit words with push, pop, peek and replace.
// ----------------------------------------------------------------------------
// The stack holds up to DEPTH words in a synchronous RAM and keeps the fill
// count in a register. Every command transfer produces one result: the popped
// or peeked word (zero otherwise), a status (ok, overflow on a full push,
// underflow on an empty pop, peek or replace) and the occupancy after the
// command. The RAM reads at the transfer edge and the result register loads
// from that read once it is free or draining. Commands are taken one per
// cycle as long as results are taken; a stall on the result side holds off
// the next command once one result waits in the output register and another
// in the read stage. Stored words are undefined after reset, but only
// written entries are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_lifo_stack (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] data,
  output logic [1:0]         status,
  output logic [4:0]         occupancy
);
  import bls_pkg::*;

  mem_req_t          mem_req;
  pend_t             pend;
  logic              take;
  logic [WORD_W-1:0] rd_data;
  logic [CNT_W-1:0]  fill;
  logic              rsp_ovf;
  logic              rsp_unf;

  // Command decode and fill count
  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .value     (value),
    .take      (take),
    .mem_req   (mem_req),
    .pend      (pend),
    .fill      (fill)
  );

  // Word storage
  bls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.addr),
    .rd_data (rd_data)
  );

  // Result register
  bls_out u_out (
    .clk       (clk),
    .rst       (rst),
    .pend      (pend),
    .rd_data   (rd_data),
    .take      (take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .data      (data),
    .status    (status),
    .occupancy (occupancy)
  );

  // Error results on the output
  assign rsp_ovf = rsp_valid && (status == ST_OVERFLOW);
  assign rsp_unf = rsp_valid && (status == ST_UNDERFLOW);

  // Checks
  `ASSERT_ALWAYS(a_rst_stall, rst |-> cmd_stall, "command taken during reset")
  `ASSERT_CLK(a_fill_bound, fill <= CNT_W'(DEPTH), "fill count exceeds depth")
  `ASSERT_CLK(a_ovf_full, rsp_ovf |-> occupancy == OCC_W'(DEPTH), "overflow below full")
  `ASSERT_CLK(a_unf_empty, rsp_unf |-> (occupancy == '0 && data == '0), "underflow not empty")

endmodule

### sim/tb_bounded_lifo_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_lifo_stack
// Self-checking bench for the bounded LIFO stack.
// ----------------------------------------------------------------------------
// A behavioral copy of the stack predicts data, status and occupancy for every
// command transfer. Each result transfer is checked in order against the
// oldest prediction. A short directed run covers the empty and full corner
// cases and the extreme values. Random traffic follows, with the push rate
// changing in phases so that the stack swings between empty and full. Both
// sides idle at random, except in one long stretch.
// ----------------------------------------------------------------------------
module tb_bounded_lifo_stack;
  import bls_pkg::*;

  localparam int RANDOM_ITEMS = 2000;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } stack_result_t;

  // Shadow stack and in-order store of predicted results
  class lifo_tracker;
    logic signed [WORD_W-1:0] words [DEPTH];
    int unsigned              fill;
    stack_result_t            expected_q [$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              pushes;
    int unsigned              overflows;
    int unsigned              underflows;
    int unsigned              times_full;

    // Apply one accepted command and queue its result
    function void note_command(cmd_e_t cmd, logic signed [WORD_W-1:0] val);
      stack_result_t r;
      r.data   = '0;
      r.status = ST_OK;
      if (cmd == CMD_PUSH) begin
        pushes++;
        if (fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
          overflows++;
        end else begin
          words[fill] = val;
          fill++;
          if (fill == DEPTH) times_full++;
        end
      end else if (fill == 0) begin
        r.status = ST_UNDERFLOW;
        underflows++;
      end else begin
        case (cmd)
          CMD_POP: begin
            fill--;
            r.data = words[fill];
          end
          CMD_PEEK: begin
            r.data = words[fill-1];
          end
          default: begin
            words[fill-1] = val;
          end
        endcase
      end
      r.occupancy = OCC_W'(fill);
      expected_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(logic signed [WORD_W-1:0] d, logic [1:0] s,
                               logic [OCC_W-1:0] occ);
      stack_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result data=%0d status=%0d occupancy=%0d",
                 $time, d, s, occ);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      checked++;
      if (d !== r.data) begin
        $display("%0t: data mismatch, expected %0d actual %0d", $time, r.data, d);
        errors++;
      end
      if (s !== r.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, r.status, s);
        errors++;
      end
      if (occ !== r.occupancy) begin
        $display("%0t: occupancy mismatch, expected %0d actual %0d",
                 $time, r.occupancy, occ);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_stall;
  logic [1:0]                command = CMD_PUSH;
  logic signed [WORD_W-1:0]  value = '0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  logic signed [WORD_W-1:0]  data;
  logic [1:0]                status;
  logic [OCC_W-1:0]          occupancy;

  bit          calm_stretch = 1'b0;
  lifo_tracker tracker;

  bounded_lifo_stack DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .data      (data),
    .status    (status),
    .occupancy (occupancy)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result-side backpressure
  always @(posedge clk) begin
    rsp_stall <= !calm_stretch && ($urandom_range(99) < 34);
  end

  // Transfer monitor: commands are noted before results so ordering holds
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) tracker.note_command(cmd_e_t'(command), value);
      if (rsp_valid && !rsp_stall) tracker.check_result(data, status, occupancy);
    end
  end

  // Offer one command, with a random gap first, and hold it until taken
  task automatic send_command(input cmd_e_t c, input logic signed [WORD_W-1:0] v);
    while (!calm_stretch && ($urandom_range(99) < 34)) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= c;
    value     <= v;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // Stop sending until every predicted result has come back; the first edge
  // lets the monitor note the last command transfer
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_q.size() != 0) @(posedge clk);
  endtask

  // Mix of extremes, small numbers and full-range words
  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return '0;
      4, 5:    return $signed(WORD_W'($urandom_range(255))) - 32'sd128;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_e_t pick_command(int push_pct);
    if ($urandom_range(99) < push_pct) return CMD_PUSH;
    return cmd_e_t'($urandom_range(3, 1));
  endfunction

  // Stimulus and end of run
  initial begin
    int push_pct;
    tracker  = new;
    push_pct = 50;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty-stack errors
    send_command(CMD_POP, 32'sd7);
    send_command(CMD_PEEK, 32'sd7);
    send_command(CMD_REPLACE, 32'sh7FFF_FFFF);
    // Single word round trip with extreme values
    send_command(CMD_PUSH, 32'sh8000_0000);
    send_command(CMD_PEEK, '0);
    send_command(CMD_REPLACE, 32'sh7FFF_FFFF);
    send_command(CMD_POP, '0);
    // Fill to the top, then overflow and peek while full
    for (int j = 0; j < DEPTH; j++) begin
      send_command(CMD_PUSH, (j % 2) ? (32'sh5555_5555 ^ j) : (32'shAAAA_AAAA ^ j));
    end
    send_command(CMD_PUSH, -32'sd1);
    send_command(CMD_PEEK, '0);

    // Random traffic, push rate changes by phase
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      calm_stretch = (i >= 1200 && i < 1500);
      if (i == 1000 || i == 1700) drain_results();
      send_command(pick_command(push_pct), pick_value());
    end
    calm_stretch = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d results: %0d pushes, %0d overflows, %0d underflows,",
             tracker.checked, tracker.pushes, tracker.overflows, tracker.underflows);
    $display("stack reached full %0d times.", tracker.times_full);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("Timeout with %0d results outstanding", tracker.expected_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/bls_pkg.sv
hw/rtl/bls_ram.sv
hw/rtl/bls_ctrl.sv
hw/rtl/bls_out.sv
hw/rtl/bounded_lifo_stack.sv
sim/tb_bounded_lifo_stack.sv
